@@ rtl/core/knn_pkg.sv @@
// ----------------------------------------------------------------------------
// knn_pkg
// shared types and constants of the k nearest neighbor search block
// ----------------------------------------------------------------------------
package knn_pkg;

  localparam int COORD_W    = 16;
  localparam int DIST_W     = 19;
  localparam int PIDX_W     = 10;
  localparam int DIMS_REG_W = 7;
  localparam int K_REG_W    = 5;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int SQ_W       = 2 * COORD_W;

  // function codes of an input item
  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIMS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_K    = 1'b1;

  typedef struct packed {
    logic [1:0]                func;
    logic signed [COORD_W-1:0] coord;
  } item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [PIDX_W-1:0] point_index;
    logic              status;
    logic              last;
  } result_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic pop;
  } cell_cmd_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } scan_req_t;

endpackage

@@ rtl/core/knn_topk_search_top.sv @@
// ----------------------------------------------------------------------------
// knn_topk_search_top
// brute force k nearest neighbor search over stored integer points
// ----------------------------------------------------------------------------
// clear, append and non-final query transfers give no result; an error
//   result shows in the cycle after the final query coordinate
// a search scans every stored point (one coordinate read per cycle from
//   the reference memory), drains the distance pipeline, then passes each
//   reported neighbor through the square root unit
// results cannot be stalled; busy is high from scan start to the last result
// reset (synchronous, active high) empties the reference set and restores
//   dims_in_use and k_in_use to 1; the memories are not cleared
module knn_topk_search_top #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_DIMS   = 64,
  parameter int MAX_K      = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  knn_pkg::item_t                      item,
  output logic                                result_strobe,
  output knn_pkg::result_t                    result,
  input  logic                                cfg_we,
  input  logic [knn_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [knn_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // address and counter widths
  localparam int AW    = (MAX_POINTS * MAX_DIMS > 1) ? $clog2(MAX_POINTS * MAX_DIMS) : 1;
  localparam int DI_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DP_W  = $clog2(MAX_DIMS + 1);
  localparam int IX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PC_W  = $clog2(MAX_POINTS + 1);
  localparam int KC_W  = $clog2(MAX_K + 1);
  localparam int SUM_W = knn_pkg::SQ_W + ((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 0);
  localparam int RT_W  = (SUM_W + 1) / 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_ROOT,
    ST_WAIT
  } state_t;

  state_t state;

  // configuration registers
  logic [knn_pkg::DIMS_REG_W-1:0] dims_in_use;
  logic [knn_pkg::K_REG_W-1:0]    k_in_use;
  logic [DP_W-1:0]                dims_eff;
  logic [KC_W-1:0]                k_eff;

  // load and query gathering state
  logic [PC_W-1:0] ref_count;
  logic [DP_W-1:0] load_pos;
  logic [AW-1:0]   load_base;
  logic [DP_W-1:0] query_pos;

  // scan sequencing
  logic [IX_W-1:0] scan_p;
  logic [DI_W-1:0] scan_j;
  logic [AW-1:0]   scan_base;
  logic [KC_W-1:0] emit_n;
  logic            chain_clr;

  logic            accept;
  logic            append_ok;
  logic            scan_last_dim;
  knn_pkg::scan_req_t req;

  logic             cand_valid;
  logic [SUM_W-1:0] cand_dist;
  logic [IX_W-1:0]  cand_point;
  logic             pipe_busy;

  logic             sqrt_done;
  logic [RT_W-1:0]  root;

  knn_pkg::cell_cmd_t cmd;
  logic             c_lt    [MAX_K];
  logic             c_valid [MAX_K];
  logic [SUM_W-1:0] c_dist  [MAX_K];
  logic [IX_W-1:0]  c_idx   [MAX_K];

  // out of range register values are clamped to the usable range
  always_comb begin
    if (dims_in_use == '0) begin
      dims_eff = DP_W'(1);
    end else if (32'(dims_in_use) > 32'(MAX_DIMS)) begin
      dims_eff = DP_W'(MAX_DIMS);
    end else begin
      dims_eff = DP_W'(dims_in_use);
    end
    if (k_in_use == '0) begin
      k_eff = KC_W'(1);
    end else if (32'(k_in_use) > 32'(MAX_K)) begin
      k_eff = KC_W'(MAX_K);
    end else begin
      k_eff = KC_W'(k_in_use);
    end
  end

  assign busy          = (state != ST_IDLE);
  assign accept        = start && !busy;
  assign append_ok     = (ref_count != PC_W'(MAX_POINTS));
  assign scan_last_dim = (32'(scan_j) + 32'd1 == 32'(dims_eff));

  // one coordinate read per scan cycle
  assign req.valid = (state == ST_SCAN);
  assign req.first = (scan_j == '0);
  assign req.last  = scan_last_dim;

  knn_dist #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_DIMS   (MAX_DIMS),
    .AW         (AW),
    .DI_W       (DI_W),
    .IX_W       (IX_W),
    .SUM_W      (SUM_W)
  ) u_dist (
    .clk        (clk),
    .rst        (rst),
    .ref_we     (accept && item.func == knn_pkg::FUNC_APPEND && append_ok),
    .ref_waddr  (load_base + AW'(load_pos)),
    .q_we       (accept && item.func == knn_pkg::FUNC_QUERY),
    .q_waddr    (query_pos[DI_W-1:0]),
    .wdata      (item.coord),
    .req        (req),
    .ref_raddr  (scan_base + AW'(scan_j)),
    .q_raddr    (scan_j),
    .req_point  (scan_p),
    .cand_valid (cand_valid),
    .cand_dist  (cand_dist),
    .cand_point (cand_point),
    .pipe_busy  (pipe_busy)
  );

  // sorted chain of best candidates, cell 0 holds the nearest
  assign cmd.clear  = chain_clr;
  assign cmd.insert = cand_valid;
  assign cmd.pop    = (state == ST_WAIT) && sqrt_done;

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    logic             l_lt, l_valid, r_valid;
    logic [SUM_W-1:0] l_dist, r_dist;
    logic [IX_W-1:0]  l_idx, r_idx;

    if (i == 0) begin : g_head
      assign l_lt    = 1'b0;
      assign l_valid = 1'b0;
      assign l_dist  = '0;
      assign l_idx   = '0;
    end else begin : g_body
      assign l_lt    = c_lt[i-1];
      assign l_valid = c_valid[i-1];
      assign l_dist  = c_dist[i-1];
      assign l_idx   = c_idx[i-1];
    end

    if (i == MAX_K - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_dist  = '0;
      assign r_idx   = '0;
    end else begin : g_mid
      assign r_valid = c_valid[i+1];
      assign r_dist  = c_dist[i+1];
      assign r_idx   = c_idx[i+1];
    end

    knn_cell #(
      .SUM_W (SUM_W),
      .IX_W  (IX_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .cand_dist   (cand_dist),
      .cand_idx    (cand_point),
      .left_lt     (l_lt),
      .left_valid  (l_valid),
      .left_dist   (l_dist),
      .left_idx    (l_idx),
      .right_valid (r_valid),
      .right_dist  (r_dist),
      .right_idx   (r_idx),
      .lt          (c_lt[i]),
      .valid       (c_valid[i]),
      .held_dist   (c_dist[i]),
      .idx         (c_idx[i])
    );
  end

  knn_sqrt #(
    .SUM_W (SUM_W)
  ) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_ROOT),
    .value (c_dist[0]),
    .done  (sqrt_done),
    .root  (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      dims_in_use   <= knn_pkg::DIMS_REG_W'(1);
      k_in_use      <= knn_pkg::K_REG_W'(1);
      ref_count     <= '0;
      load_pos      <= '0;
      load_base     <= '0;
      query_pos     <= '0;
      scan_p        <= '0;
      scan_j        <= '0;
      scan_base     <= '0;
      emit_n        <= '0;
      chain_clr     <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      chain_clr     <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          knn_pkg::REG_DIMS: dims_in_use <= cfg_data;
          knn_pkg::REG_K:    k_in_use    <= knn_pkg::K_REG_W'(cfg_data);
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (item.func)
              knn_pkg::FUNC_CLEAR: begin
                ref_count <= '0;
                load_pos  <= '0;
                load_base <= '0;
              end
              knn_pkg::FUNC_APPEND: begin
                if (append_ok) begin
                  // point completes when its last coordinate lands
                  if (load_pos + DP_W'(1) >= dims_eff) begin
                    load_pos  <= '0;
                    ref_count <= ref_count + PC_W'(1);
                    load_base <= load_base + AW'(MAX_DIMS);
                  end else begin
                    load_pos <= load_pos + DP_W'(1);
                  end
                end
              end
              knn_pkg::FUNC_QUERY: begin
                if (query_pos + DP_W'(1) >= dims_eff) begin
                  query_pos <= '0;
                  if (32'(k_eff) > 32'(ref_count)) begin
                    // too few stored points: single error result
                    result_strobe      <= 1'b1;
                    result.distance    <= '0;
                    result.point_index <= '0;
                    result.status      <= 1'b1;
                    result.last        <= 1'b1;
                  end else begin
                    state     <= ST_SCAN;
                    chain_clr <= 1'b1;
                    scan_p    <= '0;
                    scan_j    <= '0;
                    scan_base <= '0;
                  end
                end else begin
                  query_pos <= query_pos + DP_W'(1);
                end
              end
              default: ;
            endcase
          end
        end

        ST_SCAN: begin
          if (scan_last_dim) begin
            scan_j    <= '0;
            scan_p    <= scan_p + IX_W'(1);
            scan_base <= scan_base + AW'(MAX_DIMS);
            if (32'(scan_p) + 32'd1 == 32'(ref_count)) begin
              state <= ST_DRAIN;
            end
          end else begin
            scan_j <= scan_j + DI_W'(1);
          end
        end

        ST_DRAIN: begin
          // wait until the last candidate has entered the chain
          if (!pipe_busy) begin
            state  <= ST_ROOT;
            emit_n <= '0;
          end
        end

        ST_ROOT: begin
          state <= ST_WAIT;
        end

        ST_WAIT: begin
          if (sqrt_done) begin
            result_strobe      <= 1'b1;
            result.distance    <= knn_pkg::DIST_W'(root);
            result.point_index <= knn_pkg::PIDX_W'(c_idx[0]);
            result.status      <= 1'b0;
            result.last        <= (emit_n + KC_W'(1) == k_eff);
            emit_n             <= emit_n + KC_W'(1);
            state              <= (emit_n + KC_W'(1) == k_eff) ? ST_IDLE : ST_ROOT;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // error result always closes its query
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.status |-> result.last)
    else $error("error result without last");

  // no transfer goes out while the store is being scanned
  a_scan_quiet: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> !result_strobe)
    else $error("result during scan");

  // chain stays sorted: tail never below head
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    c_valid[MAX_K-1] |-> c_valid[0] && !(c_dist[MAX_K-1] < c_dist[0]))
    else $error("best list out of order");

  // results appear only while emitting or from the idle error path
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !result.status |-> $past(state) == ST_WAIT)
    else $error("result outside emit phase");

endmodule

@@ rtl/core/knn_cell.sv @@
// ----------------------------------------------------------------------------
// knn_cell
// one slot of the sorted best list, shifts with its neighbors
// ----------------------------------------------------------------------------
module knn_cell #(
  parameter int SUM_W = 38,
  parameter int IX_W  = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  knn_pkg::cell_cmd_t cmd,
  input  logic [SUM_W-1:0]   cand_dist,
  input  logic [IX_W-1:0]    cand_idx,
  input  logic               left_lt,
  input  logic               left_valid,
  input  logic [SUM_W-1:0]   left_dist,
  input  logic [IX_W-1:0]    left_idx,
  input  logic               right_valid,
  input  logic [SUM_W-1:0]   right_dist,
  input  logic [IX_W-1:0]    right_idx,
  output logic               lt,
  output logic               valid,
  output logic [SUM_W-1:0]   held_dist,
  output logic [IX_W-1:0]    idx
);

  // strict compare keeps the earlier (lower) index on ties
  assign lt = !valid || (cand_dist < held_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.clear) begin
      valid <= 1'b0;
    end else if (cmd.pop) begin
      valid <= right_valid;
    end else if (cmd.insert && lt) begin
      valid <= left_lt ? left_valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      held_dist <= right_dist;
      idx       <= right_idx;
    end else if (cmd.insert && lt) begin
      if (left_lt) begin
        held_dist <= left_dist;
        idx       <= left_idx;
      end else begin
        held_dist <= cand_dist;
        idx       <= cand_idx;
      end
    end
  end

endmodule

@@ rtl/core/knn_sqrt.sv @@
// ----------------------------------------------------------------------------
// knn_sqrt
// integer floor square root, one result bit per cycle
// ----------------------------------------------------------------------------
module knn_sqrt #(
  parameter int SUM_W = 38
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] value,
  output logic             done,
  output logic [(SUM_W+1)/2-1:0] root
);

  localparam int N    = (SUM_W + 1) / 2;
  localparam int SW   = 2 * N;
  localparam int CN_W = $clog2(N + 1);

  logic [SW-1:0]   v;
  logic [N+1:0]    rem;
  logic [N+1:0]    rem_sh;
  logic [N+1:0]    trial;
  logic [CN_W-1:0] cnt;
  logic            active;

  assign rem_sh = {rem[N-1:0], v[SW-1:SW-2]};
  assign trial  = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        v      <= SW'(value);
        rem    <= '0;
        root   <= '0;
        cnt    <= '0;
      end else if (active) begin
        v <= v << 2;
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[N-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[N-2:0], 1'b0};
        end
        cnt <= cnt + CN_W'(1);
        if (cnt == CN_W'(N - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/core/knn_dist.sv @@
// ----------------------------------------------------------------------------
// knn_dist
// reference and query storage with the squared distance datapath
// ----------------------------------------------------------------------------
module knn_dist #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_DIMS   = 64,
  parameter int AW         = 16,
  parameter int DI_W       = 6,
  parameter int IX_W       = 10,
  parameter int SUM_W      = 38
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               ref_we,
  input  logic [AW-1:0]                      ref_waddr,
  input  logic                               q_we,
  input  logic [DI_W-1:0]                    q_waddr,
  input  logic signed [knn_pkg::COORD_W-1:0] wdata,
  input  knn_pkg::scan_req_t                 req,
  input  logic [AW-1:0]                      ref_raddr,
  input  logic [DI_W-1:0]                    q_raddr,
  input  logic [IX_W-1:0]                    req_point,
  output logic                               cand_valid,
  output logic [SUM_W-1:0]                   cand_dist,
  output logic [IX_W-1:0]                    cand_point,
  output logic                               pipe_busy
);

  localparam int CW = knn_pkg::COORD_W;

  logic signed [CW-1:0] ref_mem [MAX_POINTS*MAX_DIMS];
  logic signed [CW-1:0] query_mem [MAX_DIMS];

  logic signed [CW-1:0]  ref_q;
  logic signed [CW-1:0]  qry_q;
  knn_pkg::scan_req_t    s1, s2, s3;
  logic [IX_W-1:0]       p1, p2, p3;
  logic signed [CW:0]    sub;
  logic [CW-1:0]         diff;
  logic [knn_pkg::SQ_W-1:0] sq;

  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_mem[ref_waddr] <= wdata;
    end
    if (q_we) begin
      query_mem[q_waddr] <= wdata;
    end
    ref_q <= ref_mem[ref_raddr];
    qry_q <= query_mem[q_raddr];
  end

  assign sub = {ref_q[CW-1], ref_q} - {qry_q[CW-1], qry_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1         <= '0;
      s2         <= '0;
      s3         <= '0;
      cand_valid <= 1'b0;
    end else begin
      s1         <= req;
      s2         <= s1;
      s3         <= s2;
      cand_valid <= s3.valid && s3.last;
    end
  end

  always_ff @(posedge clk) begin
    p1   <= req_point;
    p2   <= p1;
    p3   <= p2;
    diff <= CW'(sub[CW] ? (~sub + (CW+1)'(1)) : sub);
    sq   <= knn_pkg::SQ_W'(diff) * knn_pkg::SQ_W'(diff);
    if (s3.valid) begin
      cand_dist  <= (s3.first ? '0 : cand_dist) + SUM_W'(sq);
      cand_point <= p3;
    end
  end

  assign pipe_busy = s1.valid || s2.valid || s3.valid || cand_valid;

endmodule

@@ bench/knn_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// knn_checker
// watches the item, result and register ports of the neighbor search block,
// predicts the neighbor list of every finished query and compares each result
// with the oldest prediction
// ----------------------------------------------------------------------------
module knn_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  knn_pkg::item_t                 item,
  input  logic                           result_strobe,
  input  knn_pkg::result_t               result,
  input  logic                           cfg_we,
  input  logic [knn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [knn_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             pending
);

  localparam int N_POINTS = 1024;
  localparam int N_DIMS   = 64;
  localparam int N_K      = 16;

  logic signed [knn_pkg::COORD_W-1:0] point_coords [0:N_POINTS-1][0:N_DIMS-1];
  logic signed [knn_pkg::COORD_W-1:0] probe_coords [0:N_DIMS-1];
  int unsigned                        n_points;
  int unsigned                        load_pos;
  int unsigned                        probe_pos;
  logic [knn_pkg::DIMS_REG_W-1:0]     dims_reg;
  logic [knn_pkg::K_REG_W-1:0]        k_reg;
  knn_pkg::result_t                   neighbors_due [$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic int unsigned live_dims();
    if (dims_reg == 0) return 1;
    if (dims_reg > N_DIMS) return N_DIMS;
    return dims_reg;
  endfunction

  function automatic int unsigned live_k();
    if (k_reg == 0) return 1;
    if (k_reg > N_K) return N_K;
    return k_reg;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 19; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // ranks every stored point against the probe, ties keep the lower index; too few points give one error result
  task automatic rank_points();
    longint unsigned  best_d [N_K];
    int unsigned      best_i [N_K];
    int unsigned      filled;
    int unsigned      dims;
    int unsigned      k;
    int unsigned      pos;
    longint unsigned  sum;
    longint           diff;
    knn_pkg::result_t r;
    dims   = live_dims();
    k      = live_k();
    filled = 0;
    if (k > n_points) begin
      r = '0;
      r.status = 1'b1;
      r.last   = 1'b1;
      neighbors_due.push_back(r);
      return;
    end
    for (int unsigned p = 0; p < n_points; p++) begin
      sum = 0;
      for (int unsigned j = 0; j < dims; j++) begin
        diff = longint'(point_coords[p][j]) - longint'(probe_coords[j]);
        if (diff < 0) diff = -diff;
        sum += longint'(diff * diff);
      end
      pos = filled;
      while (pos > 0 && sum < best_d[pos-1]) pos--;
      if (pos < k) begin
        for (int unsigned i = (filled < k) ? filled : k - 1; i > pos; i--) begin
          best_d[i] = best_d[i-1];
          best_i[i] = best_i[i-1];
        end
        best_d[pos] = sum;
        best_i[pos] = p;
        if (filled < k) filled++;
      end
    end
    for (int unsigned i = 0; i < k; i++) begin
      r.distance    = knn_pkg::DIST_W'(floor_root(best_d[i]));
      r.point_index = knn_pkg::PIDX_W'(best_i[i]);
      r.status      = 1'b0;
      r.last        = (i + 1 == k);
      neighbors_due.push_back(r);
    end
  endtask

  task automatic take_item(knn_pkg::item_t it);
    case (it.func)
      knn_pkg::FUNC_CLEAR: begin
        n_points = 0;
        load_pos = 0;
      end
      knn_pkg::FUNC_APPEND: begin
        if (n_points < N_POINTS) begin
          point_coords[n_points][load_pos] = it.coord;
          load_pos++;
          if (load_pos >= live_dims()) begin
            load_pos = 0;
            n_points++;
          end
        end
      end
      knn_pkg::FUNC_QUERY: begin
        probe_coords[probe_pos] = it.coord;
        probe_pos++;
        if (probe_pos >= live_dims()) begin
          probe_pos = 0;
          rank_points();
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result(knn_pkg::result_t got);
    knn_pkg::result_t want;
    if (neighbors_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t unexpected result %p", $realtime, got);
      return;
    end
    want = neighbors_due.pop_front();
    if (got.distance !== want.distance || got.point_index !== want.point_index ||
        got.status !== want.status || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t result mismatch: expected %p, got %p", $realtime, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      n_points  = 0;
      load_pos  = 0;
      probe_pos = 0;
      dims_reg  = 1;
      k_reg     = 1;
      neighbors_due.delete();
    end else begin
      if (result_strobe) check_result(result);
      if (cfg_we) begin
        case (cfg_index)
          knn_pkg::REG_DIMS: dims_reg = cfg_data[knn_pkg::DIMS_REG_W-1:0];
          knn_pkg::REG_K:    k_reg    = cfg_data[knn_pkg::K_REG_W-1:0];
          default:  ;
        endcase
      end
      if (start && !busy) take_item(item);
    end
    pending = neighbors_due.size();
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the k nearest neighbor search block: directed
// corner cases, register extremes, then random point and query traffic
// under three idling patterns
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 1000000;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           start = 1'b0;
  logic                           busy;
  knn_pkg::item_t                 item = '0;
  logic                           result_strobe;
  knn_pkg::result_t               result;
  logic                           cfg_we = 1'b0;
  logic [knn_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [knn_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  int                             mismatches;
  int                             pending;
  int                             cycles = 0;

  // mirror of the block's view, needed to keep dims changes legal
  int unsigned idle_pct   = 0;
  int unsigned cur_dims   = 1;
  int unsigned probe_pos  = 0;
  int unsigned items_sent = 0;

  // clock: 20 ns period
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  knn_topk_search_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result_strobe (result_strobe),
    .result        (result),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  knn_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result_strobe (result_strobe),
    .result        (result),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // coordinates lean toward the extremes and small values so ties occur
  function automatic logic [knn_pkg::COORD_W-1:0] pick_coord();
    case ($urandom_range(3))
      0: case ($urandom_range(3))
           0: return 16'h8000;
           1: return 16'h7fff;
           2: return 16'h0000;
           default: return 16'hffff;
         endcase
      1: return knn_pkg::COORD_W'($urandom_range(6)) - knn_pkg::COORD_W'(3);
      default: return knn_pkg::COORD_W'($urandom);
    endcase
  endfunction

  // called at a rising edge, returns at the edge of the transfer
  task automatic send_item(logic [1:0] f, logic [knn_pkg::COORD_W-1:0] c);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    item  <= '{func: f, coord: c};
    // busy only moves at rising edges, so mid-cycle sampling is race free
    do @(negedge clk); while (busy);
    @(posedge clk);
    items_sent++;
    if (f == knn_pkg::FUNC_QUERY) begin
      probe_pos++;
      if (probe_pos >= cur_dims) probe_pos = 0;
    end
  endtask

  // hold off until every neighbor is out and the search unit is idle
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [knn_pkg::CFG_IDX_W-1:0] idx,
                           logic [knn_pkg::CFG_DATA_W-1:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // finish any half-gathered query, change dims, then empty the store so no
  // point is read past the coordinates it was loaded with
  task automatic set_dims(logic [knn_pkg::CFG_DATA_W-1:0] val);
    while (probe_pos != 0) send_item(knn_pkg::FUNC_QUERY, pick_coord());
    write_reg(knn_pkg::REG_DIMS, val);
    cur_dims = (val == 0) ? 1 : (val > 64) ? 64 : val;
    send_item(knn_pkg::FUNC_CLEAR, pick_coord());
  endtask

  task automatic load_point();
    for (int unsigned j = 0; j < cur_dims; j++) send_item(knn_pkg::FUNC_APPEND, pick_coord());
  endtask

  task automatic run_query();
    for (int unsigned j = 0; j < cur_dims; j++) send_item(knn_pkg::FUNC_QUERY, pick_coord());
  endtask

  task automatic random_traffic(int unsigned n_items);
    int unsigned target;
    int unsigned pick;
    target = items_sent + n_items;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 4) set_dims(knn_pkg::CFG_DATA_W'($urandom_range(1, 4)));
      else if (pick < 8)
        write_reg(knn_pkg::REG_K, ($urandom_range(4) == 0) ? 7'd16 : 7'($urandom_range(1, 8)));
      else if (pick < 58) load_point();
      else if (pick < 80) run_query();
      else if (pick < 85) send_item(knn_pkg::FUNC_CLEAR, pick_coord());
      else if (pick < 90) send_item(2'd3, pick_coord());
      else if (pick < 95) send_item(knn_pkg::FUNC_APPEND, pick_coord());
      else send_item(knn_pkg::FUNC_QUERY, pick_coord());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty store, extremes, ties, unused code, k above count
    send_item(knn_pkg::FUNC_QUERY, 16'd5);
    send_item(knn_pkg::FUNC_APPEND, 16'h7fff);
    send_item(knn_pkg::FUNC_APPEND, 16'h8000);
    send_item(knn_pkg::FUNC_APPEND, 16'h0000);
    send_item(knn_pkg::FUNC_APPEND, 16'h0000);
    send_item(2'd3, 16'hffff);
    send_item(knn_pkg::FUNC_QUERY, 16'h0000);
    write_reg(knn_pkg::REG_K, 7'd3);
    send_item(knn_pkg::FUNC_QUERY, 16'h8000);
    send_item(knn_pkg::FUNC_QUERY, 16'h7fff);
    write_reg(knn_pkg::REG_K, 7'd31);
    send_item(knn_pkg::FUNC_QUERY, 16'd1);
    write_reg(knn_pkg::REG_K, 7'd0);
    send_item(knn_pkg::FUNC_QUERY, 16'hffff);
    send_item(knn_pkg::FUNC_CLEAR, 16'h1234);
    send_item(knn_pkg::FUNC_QUERY, 16'd0);

    // register extremes: dims of zero with k at its top
    set_dims(7'd0);
    write_reg(knn_pkg::REG_K, 7'd31);
    repeat (20) load_point();
    run_query();
    set_dims(7'd2);
    write_reg(knn_pkg::REG_K, 7'd1);

    // random traffic under the three idling patterns
    idle_pct = 10;
    random_traffic(30);
    settle();
    idle_pct = 78;
    random_traffic(30);
    settle();
    idle_pct = 0;
    random_traffic(30);
    while (probe_pos != 0) send_item(knn_pkg::FUNC_QUERY, pick_coord());
    settle();

    if (mismatches == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/knn_pkg.sv
rtl/core/knn_cell.sv
rtl/core/knn_sqrt.sv
rtl/core/knn_dist.sv
rtl/core/knn_topk_search_top.sv
bench/knn_checker.sv
bench/testbench.sv
